FILE: src/kvnp_pkg.sv
// Package for the key/value number parser.
// Holds shared widths, configuration register indexes, outcome codes and the result record.
// No dependencies.
package kvnp_pkg;

  localparam int KEY_MAX_CHARS_DEF = 8;
  localparam int CHAR_W            = 8;
  localparam int VALUE_W           = 32;
  localparam int KEY_LEN_W         = 4;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_TEXT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 1'd1;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_ABSENT    = 3'd1,
    ERR_BAD_DIGIT = 3'd2,
    ERR_OVERFLOW  = 3'd3,
    ERR_EMPTY     = 3'd4
  } err_kind_t;

  typedef struct packed {
    logic               found_ok;
    err_kind_t          error_kind;
    logic [VALUE_W-1:0] parsed_value;
  } res_t;

endpackage

FILE: src/kvnp_cfg.sv
// Configuration registers of the key/value number parser: key characters and key length.
// Depends on kvnp_pkg.
module kvnp_cfg #(
  parameter int KEY_MAX_CHARS = kvnp_pkg::KEY_MAX_CHARS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [kvnp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kvnp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic [kvnp_pkg::CHAR_W-1:0]      key_o [KEY_MAX_CHARS],
  output logic [kvnp_pkg::KEY_LEN_W-1:0]   key_len_o
);
  import kvnp_pkg::*;

  logic [CHAR_W-1:0]    key_r [KEY_MAX_CHARS];
  logic [KEY_LEN_W-1:0] key_len_r;
  logic [KEY_LEN_W-1:0] key_len_nxt;

  // clamp to the supported key size
  always_comb begin
    if (key_len_r > KEY_LEN_W'(KEY_MAX_CHARS)) begin
      key_len_nxt = KEY_LEN_W'(KEY_MAX_CHARS);
    end else begin
      key_len_nxt = key_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_MAX_CHARS; i++) begin
        key_r[i] <= '0;
      end
      key_len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_TEXT: begin
          for (int i = 0; i < KEY_MAX_CHARS; i++) begin
            key_r[i] <= cfg_wdata[CHAR_W*i +: CHAR_W];
          end
        end
        CFG_KEY_LEN: begin
          key_len_r <= cfg_wdata[KEY_LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign key_o     = key_r;
  assign key_len_o = key_len_nxt;

endmodule

FILE: src/kvnp_step.sv
// Per-character parse state machine and decimal/hex accumulator.
// Produces one result record at each end-of-line transfer. Depends on kvnp_pkg.
module kvnp_step #(
  parameter int KEY_MAX_CHARS = kvnp_pkg::KEY_MAX_CHARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            xfer_i,
  input  logic [kvnp_pkg::CHAR_W-1:0]     char_i,
  input  logic [kvnp_pkg::CHAR_W-1:0]     key_i [KEY_MAX_CHARS],
  input  logic [kvnp_pkg::KEY_LEN_W-1:0]  key_len_i,
  output logic                            res_valid_o,
  output kvnp_pkg::res_t                  res_o
);
  import kvnp_pkg::*;

  localparam int KEY_IDX_W = (KEY_MAX_CHARS > 1) ? $clog2(KEY_MAX_CHARS) : 1;

  typedef enum logic [2:0] {
    PH_BETWEEN,
    PH_MATCH,
    PH_SKIP,
    PH_VSTART,
    PH_AFTER0,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  phase_t               ph_r, ph_nxt;
  logic [KEY_LEN_W-1:0] pos_r, pos_nxt;
  logic [VALUE_W-1:0]   acc_r, acc_nxt;
  logic                 hex_r, hex_nxt;
  logic                 seen_r, seen_nxt;
  err_kind_t            oc_r, oc_nxt;

  logic                 is_space;
  logic                 is_eol;
  logic [KEY_LEN_W-1:0] pos;
  logic                 dig_ok;
  logic [3:0]           dig;
  logic [VALUE_W+3:0]   prod;
  logic [VALUE_W+4:0]   sum;
  logic                 ovf;
  err_kind_t            eol_oc;

  assign is_space = (char_i == CH_SPACE) || (char_i == CH_TAB);
  assign is_eol   = (char_i == CH_NUL);
  assign pos      = (ph_r == PH_BETWEEN) ? '0 : pos_r;

  // digit decode in the current base
  always_comb begin
    dig_ok = 1'b1;
    dig    = '0;
    if (char_i >= CH_ZERO && char_i <= CH_NINE) begin
      dig = 4'(char_i - CH_ZERO);
    end else if (hex_r && char_i >= CH_LO_A && char_i <= CH_LO_F) begin
      dig = 4'(char_i - CH_LO_A + 8'd10);
    end else if (hex_r && char_i >= CH_UP_A && char_i <= CH_UP_F) begin
      dig = 4'(char_i - CH_UP_A + 8'd10);
    end else begin
      dig_ok = 1'b0;
    end
  end

  // acc * base + digit; anything above 32 bits is an overflow
  assign prod = hex_r ? {acc_r, 4'b0000}
                      : ({1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0});
  assign sum  = {1'b0, prod} + {{(VALUE_W+1){1'b0}}, dig};
  assign ovf  = |sum[VALUE_W+4:VALUE_W];

  always_comb begin
    if (ph_r == PH_VSTART || ph_r == PH_AFTER0 || ph_r == PH_DIGITS) begin
      eol_oc = seen_r ? ERR_NONE : ERR_EMPTY;
    end else if (ph_r != PH_DONE) begin
      eol_oc = ERR_ABSENT;
    end else begin
      eol_oc = oc_r;
    end
  end

  always_comb begin
    ph_nxt   = ph_r;
    pos_nxt  = pos_r;
    acc_nxt  = acc_r;
    hex_nxt  = hex_r;
    seen_nxt = seen_r;
    oc_nxt   = oc_r;
    if (is_eol) begin
      ph_nxt   = PH_BETWEEN;
      pos_nxt  = '0;
      acc_nxt  = '0;
      hex_nxt  = 1'b0;
      seen_nxt = 1'b0;
      oc_nxt   = ERR_ABSENT;
    end else begin
      case (ph_r)
        PH_BETWEEN, PH_MATCH: begin
          if (is_space) begin
            ph_nxt  = PH_BETWEEN;
            pos_nxt = '0;
          end else if (pos >= key_len_i) begin
            if (char_i == CH_EQ) begin
              ph_nxt   = PH_VSTART;
              acc_nxt  = '0;
              hex_nxt  = 1'b0;
              seen_nxt = 1'b0;
            end else begin
              ph_nxt = PH_SKIP;
            end
          end else if (char_i == key_i[pos[KEY_IDX_W-1:0]]) begin
            ph_nxt  = PH_MATCH;
            pos_nxt = pos + 1'b1;
          end else begin
            ph_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (is_space) begin
            ph_nxt  = PH_BETWEEN;
            pos_nxt = '0;
          end
        end
        PH_VSTART, PH_AFTER0, PH_DIGITS: begin
          if (is_space) begin
            oc_nxt = seen_r ? ERR_NONE : ERR_EMPTY;
            ph_nxt = PH_DONE;
          end else if (ph_r == PH_VSTART && char_i == CH_ZERO) begin
            acc_nxt  = '0;
            seen_nxt = 1'b1;
            ph_nxt   = PH_AFTER0;
          end else if (ph_r == PH_AFTER0 && (char_i == CH_LO_X || char_i == CH_UP_X)) begin
            hex_nxt  = 1'b1;
            acc_nxt  = '0;
            seen_nxt = 1'b0;
            ph_nxt   = PH_DIGITS;
          end else if (!dig_ok) begin
            oc_nxt = ERR_BAD_DIGIT;
            ph_nxt = PH_DONE;
          end else if (ovf) begin
            oc_nxt = ERR_OVERFLOW;
            ph_nxt = PH_DONE;
          end else begin
            acc_nxt  = sum[VALUE_W-1:0];
            seen_nxt = 1'b1;
            ph_nxt   = PH_DIGITS;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_BETWEEN;
      pos_r  <= '0;
      acc_r  <= '0;
      hex_r  <= 1'b0;
      seen_r <= 1'b0;
      oc_r   <= ERR_ABSENT;
    end else if (xfer_i) begin
      ph_r   <= ph_nxt;
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      hex_r  <= hex_nxt;
      seen_r <= seen_nxt;
      oc_r   <= oc_nxt;
    end
  end

  assign res_valid_o        = xfer_i && is_eol;
  assign res_o.found_ok     = (eol_oc == ERR_NONE);
  assign res_o.error_kind   = eol_oc;
  assign res_o.parsed_value = (eol_oc == ERR_NONE) ? acc_r : '0;

endmodule

FILE: src/kvnp_out.sv
// Output register of the key/value number parser: holds one result until it is taken.
// Depends on kvnp_pkg.
module kvnp_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid_i,
  input  kvnp_pkg::res_t res_i,
  input  logic           out_ready,
  output logic           out_valid,
  output logic           space_o,
  output kvnp_pkg::res_t res_o
);
  import kvnp_pkg::*;

  logic valid_r;
  res_t res_r;

  assign space_o = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid_i) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid_i) begin
      res_r <= res_i;
    end
  end

  assign out_valid = valid_r;
  assign res_o     = res_r;

endmodule

FILE: src/key_value_number_parser.sv
// Top level of the key/value number parser.
// Depends on kvnp_pkg, kvnp_cfg, kvnp_step and kvnp_out.
//
// Usage:
//   in_* channel: one character per transfer (valid/ready). A zero character
//   ends the line; every other character produces no result.
//   out_* channel: one result per line (found_ok, error_kind, parsed_value),
//   valid/ready.
//   cfg_*: write port; index 0 is the key text (first character in the low byte),
//   index 1 the key length. Write only while no line is in progress.
// Timing:
//   One character is taken every cycle while in_ready is high. The result for a line appears on out_*
//   in the cycle after the zero character is transferred, from the output register.
//   in_ready drops only while a result is held and out_ready is low; the
//   character path is a single register stage through the parse state machine.
// Reset:
//   Synchronous, active low; clears the key registers and the parse state and
//   empties the output register.
module key_value_number_parser #(
  parameter int KEY_MAX_CHARS = kvnp_pkg::KEY_MAX_CHARS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [kvnp_pkg::CHAR_W-1:0]      in_character,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_found_ok,
  output logic [2:0]                       out_error_kind,
  output logic [kvnp_pkg::VALUE_W-1:0]     out_parsed_value,
  input  logic                             cfg_we,
  input  logic [kvnp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kvnp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import kvnp_pkg::*;

  logic [CHAR_W-1:0]    key [KEY_MAX_CHARS];
  logic [KEY_LEN_W-1:0] key_len;
  logic                 xfer;
  logic                 res_valid;
  res_t                 res;
  res_t                 res_q;

  assign xfer = in_valid && in_ready;

  kvnp_cfg #(.KEY_MAX_CHARS(KEY_MAX_CHARS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .key_o     (key),
    .key_len_o (key_len)
  );

  kvnp_step #(.KEY_MAX_CHARS(KEY_MAX_CHARS)) u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .xfer_i      (xfer),
    .char_i      (in_character),
    .key_i       (key),
    .key_len_i   (key_len),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  kvnp_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .space_o     (in_ready),
    .res_o       (res_q)
  );

  assign out_found_ok     = res_q.found_ok;
  assign out_error_kind   = res_q.error_kind;
  assign out_parsed_value = res_q.parsed_value;

endmodule

FILE: src/kvnp_checker.sv
// Port-level checks for the key/value number parser, bound to the top level.
// Depends on kvnp_pkg and key_value_number_parser.
module kvnp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [kvnp_pkg::CHAR_W-1:0]  in_character,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_found_ok,
  input logic [2:0]                   out_error_kind,
  input logic [kvnp_pkg::VALUE_W-1:0] out_parsed_value
);
  import kvnp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_error_kind)
      && $stable(out_parsed_value))
    else $error("result changed while stalled");

  a_eol_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_character == CH_NUL |=> out_valid)
    else $error("no result after end of line");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_character == CH_NUL))
    else $error("result without end of line");

  a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found_ok == (out_error_kind == ERR_NONE)))
    else $error("found_ok disagrees with error_kind");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found_ok |-> out_parsed_value == '0)
    else $error("nonzero value on failed parse");

endmodule

bind key_value_number_parser kvnp_checker u_kvnp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_character     (in_character),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_found_ok     (out_found_ok),
  .out_error_kind   (out_error_kind),
  .out_parsed_value (out_parsed_value)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench: directed lines, then random lines under several key settings,
// checked against an in-bench parser model. Depends on kvnp_pkg and key_value_number_parser.
module testbench;
  import kvnp_pkg::*;

  localparam int KEY_CHARS    = KEY_MAX_CHARS_DEF;
  localparam int RANDOM_CHARS = 1050;
  localparam int TIMEOUT_NS   = 6_000_000;
  localparam int PRINT_LIMIT  = 50;

  typedef enum logic [2:0] {
    SCAN_GAP,
    SCAN_KEY,
    SCAN_SKIP,
    VAL_START,
    VAL_AFTER_ZERO,
    VAL_DIGITS,
    LINE_DONE
  } scan_state_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [CHAR_W-1:0]     in_character;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_found_ok;
  logic [2:0]            out_error_kind;
  logic [VALUE_W-1:0]    out_parsed_value;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // parser model state
  logic [63:0]        key_text_q;
  logic [3:0]         key_len_q;
  scan_state_t        scan;
  logic [3:0]         key_pos;
  logic [31:0]        acc;
  logic               hex_base;
  logic               got_digit;
  err_kind_t          outcome;

  res_t               pending_results[$];
  logic [7:0]         line_bytes[$];
  int                 error_count;
  int                 chars_sent;
  bit                 steady;

  key_value_number_parser i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_character     (in_character),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found_ok     (out_found_ok),
    .out_error_kind   (out_error_kind),
    .out_parsed_value (out_parsed_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void restart_line();
    scan      = SCAN_GAP;
    key_pos   = '0;
    acc       = '0;
    hex_base  = 1'b0;
    got_digit = 1'b0;
    outcome   = ERR_ABSENT;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic void match_key_char(logic [7:0] c);
    logic [3:0] klen;
    klen = (key_len_q > KEY_CHARS) ? 4'(KEY_CHARS) : key_len_q;
    if (key_pos >= klen) begin
      if (c == CH_EQ) begin
        scan      = VAL_START;
        acc       = '0;
        hex_base  = 1'b0;
        got_digit = 1'b0;
      end else begin
        scan = SCAN_SKIP;
      end
    end else if (c == key_text_q[8*key_pos[2:0] +: 8]) begin
      key_pos = key_pos + 4'd1;
      scan    = SCAN_KEY;
    end else begin
      scan = SCAN_SKIP;
    end
  endfunction

  // bad digit is checked before overflow
  function automatic void take_digit(logic [7:0] c);
    logic [31:0] radix;
    logic [31:0] d;
    radix = hex_base ? 32'd16 : 32'd10;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 32'(c - CH_ZERO);
    end else if (hex_base && c >= CH_LO_A && c <= CH_LO_F) begin
      d = 32'(c - CH_LO_A) + 32'd10;
    end else if (hex_base && c >= CH_UP_A && c <= CH_UP_F) begin
      d = 32'(c - CH_UP_A) + 32'd10;
    end else begin
      outcome = ERR_BAD_DIGIT;
      scan    = LINE_DONE;
      return;
    end
    if (acc > (32'hFFFF_FFFF - d) / radix) begin
      outcome = ERR_OVERFLOW;
      scan    = LINE_DONE;
      return;
    end
    acc       = acc * radix + d;
    got_digit = 1'b1;
    scan      = VAL_DIGITS;
  endfunction

  function automatic void close_value();
    outcome = got_digit ? ERR_NONE : ERR_EMPTY;
    scan    = LINE_DONE;
  endfunction

  function automatic void parse_char(logic [7:0] c);
    res_t r;
    if (c == CH_NUL) begin
      if (scan == VAL_START || scan == VAL_AFTER_ZERO || scan == VAL_DIGITS) begin
        close_value();
      end else if (scan != LINE_DONE) begin
        outcome = ERR_ABSENT;
      end
      r.found_ok     = (outcome == ERR_NONE);
      r.error_kind   = outcome;
      r.parsed_value = (outcome == ERR_NONE) ? acc : '0;
      pending_results.push_back(r);
      restart_line();
      return;
    end
    case (scan)
      SCAN_GAP: begin
        if (!is_blank(c)) begin
          key_pos = '0;
          match_key_char(c);
        end
      end
      SCAN_KEY: begin
        if (is_blank(c)) begin
          scan    = SCAN_GAP;
          key_pos = '0;
        end else begin
          match_key_char(c);
        end
      end
      SCAN_SKIP: begin
        if (is_blank(c)) begin
          scan    = SCAN_GAP;
          key_pos = '0;
        end
      end
      VAL_START: begin
        if (is_blank(c)) begin
          close_value();
        end else if (c == CH_ZERO) begin
          acc       = '0;
          got_digit = 1'b1;
          scan      = VAL_AFTER_ZERO;
        end else begin
          take_digit(c);
        end
      end
      VAL_AFTER_ZERO: begin
        if (is_blank(c)) begin
          close_value();
        end else if (c == CH_LO_X || c == CH_UP_X) begin
          hex_base  = 1'b1;
          acc       = '0;
          got_digit = 1'b0;
          scan      = VAL_DIGITS;
        end else begin
          take_digit(c);
        end
      end
      VAL_DIGITS: begin
        if (is_blank(c)) begin
          close_value();
        end else begin
          take_digit(c);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < PRINT_LIMIT) begin
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
    error_count++;
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_parsed_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_found_ok !== want.found_ok) begin
          report_mismatch("found_ok", 32'(out_found_ok), 32'(want.found_ok));
        end
        if (out_error_kind !== want.error_kind) begin
          report_mismatch("error_kind", 32'(out_error_kind), 32'(want.error_kind));
        end
        if (out_parsed_value !== want.parsed_value) begin
          report_mismatch("parsed_value", out_parsed_value, want.parsed_value);
        end
      end
    end
  end

  // result side back-pressure
  initial begin : result_sink
    int hold;
    int r;
    out_ready = 1'b0;
    hold      = 0;
    forever begin
      @(posedge clk);
      if (steady) begin
        out_ready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
          hold = $urandom_range(0, 6);
        end else if (r < 94) begin
          out_ready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          out_ready <= 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_char(logic [7:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= c;
    do @(posedge clk); while (!in_ready);
    parse_char(c);
    chars_sent++;
  endtask

  task automatic flush_line();
    foreach (line_bytes[i]) send_char(line_bytes[i]);
    send_char(CH_NUL);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endfunction

  task automatic send_line(string s);
    line_bytes.delete();
    push_text(s);
    flush_line();
  endtask

  // stop sending until every result is back, then give the block time to settle
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_key(logic [63:0] text, logic [3:0] len);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_TEXT;
    cfg_wdata <= text;
    @(posedge clk);
    key_text_q = text;
    cfg_index <= CFG_KEY_LEN;
    cfg_wdata <= {junk[63:4], len};
    @(posedge clk);
    key_len_q = len;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] pack_key(string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  function automatic void push_blank();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) line_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  function automatic void push_key(bit spoil);
    int n;
    bit drop_eq;
    n       = (key_len_q > KEY_CHARS) ? KEY_CHARS : key_len_q;
    drop_eq = spoil && (n == 0 || $urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      if (spoil && !drop_eq && i == n - 1) begin
        line_bytes.push_back(8'($urandom_range(33, 126)));
      end else begin
        line_bytes.push_back(key_text_q[8*i +: 8]);
      end
    end
    if (!drop_eq) line_bytes.push_back(CH_EQ);
  endfunction

  function automatic void push_value();
    int r;
    int p;
    logic [63:0] v;
    logic [7:0] bad;
    string s;
    string pre;
    r   = $urandom_range(0, 99);
    bad = 8'($urandom_range(1, 255));
    p   = -1;
    if (r < 30 || (r >= 80 && r < 86)) begin
      v = 64'($urandom >> $urandom_range(0, 31));
      s = $sformatf("%0d", v);
    end else if (r < 42) begin
      if ($urandom_range(0, 1)) v = 64'd4294967285 + 64'($urandom_range(0, 20));
      else v = {$urandom, $urandom} >> $urandom_range(20, 40);
      s = $sformatf("%0d", v);
    end else if (r < 64 || (r >= 86 && r < 92)) begin
      v = {$urandom, $urandom} >> $urandom_range(28, 63);
      s = $sformatf("%0h", v);
      for (int i = 0; i < s.len(); i++) begin
        if (s[i] >= "a" && $urandom_range(0, 1)) s[i] = s[i] - 8'd32;
      end
      pre = $urandom_range(0, 1) ? "0x" : "0X";
      s   = {pre, s};
    end else if (r < 70) begin
      s = "0";
    end else if (r < 75) begin
      s = $urandom_range(0, 1) ? "0x" : "0X";
    end else if (r < 80) begin
      s = "";
    end else begin
      s = {"00", $sformatf("%0d", $urandom_range(0, 99999))};
    end
    if (r >= 80 && r < 92) p = $urandom_range(0, s.len());
    for (int i = 0; i < s.len(); i++) begin
      if (i == p) line_bytes.push_back(bad);
      line_bytes.push_back(s[i]);
    end
    if (p == s.len()) line_bytes.push_back(bad);
  endfunction

  // mostly key=value tokens, some near misses, plain words and raw bytes
  function automatic void build_line();
    int ntok;
    int r;
    line_bytes.delete();
    if ($urandom_range(0, 3) == 0) push_blank();
    ntok = $urandom_range(0, 4);
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) push_blank();
      r = $urandom_range(0, 99);
      if (r < 50) begin
        push_key(1'b0);
        push_value();
      end else if (r < 65) begin
        push_key(1'b1);
        push_value();
      end else if (r < 85) begin
        repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(33, 126)));
      end else begin
        repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(1, 255)));
      end
    end
    if ($urandom_range(0, 1)) push_blank();
  endfunction

  task automatic test_after_reset();
    send_line("");
    send_line("=42");
    send_line("x =7");
  endtask

  task automatic test_number_limits();
    load_key(pack_key("n"), 4'd1);
    send_line("n=4294967295");
    send_line("n=4294967296");
    send_line("n=0xFFFFFFFF");
    send_line("n=0x100000000");
    send_line("n=0X1aF");
    send_line("n=0");
    send_line("n=007");
  endtask

  task automatic test_empty_values();
    send_line("n=0x");
    send_line("n=");
    send_line("n= n=5");
    send_line("n=0X\t");
  endtask

  task automatic test_first_error();
    send_line("n=12a9");
    send_line("n=99999999999z");
    send_line("n=0xg1");
  endtask

  task automatic test_token_choice();
    send_line(" \tnn=3 n=4");
    send_line("a n=5 n=7");
    send_line("n=6\t");
  endtask

  task automatic test_key_corners();
    load_key(pack_key("abcdefgh"), 4'd15);
    send_line("abcdefgh=6");
    load_key(pack_key("a b"), 4'd3);
    send_line("a b=1");
    load_key(64'h0, 4'd1);
    send_line("=2 x=3");
    load_key(pack_key("q"), 4'd0);
    send_line("=9");
  endtask

  task automatic test_random_lines();
    int start;
    int round;
    int phase_end;
    logic [63:0] text;
    logic [3:0] len;
    start = chars_sent;
    round = 0;
    while (chars_sent < start + RANDOM_CHARS) begin
      for (int i = 0; i < 8; i++) text[8*i +: 8] = 8'($urandom_range(33, 126));
      len = 4'($urandom_range(1, 8));
      case (round % 6)
        0: len = 4'd15;
        1: len = 4'd0;
        2: begin
          text = '1;
          len  = 4'd8;
        end
        3: begin
          text = {$urandom, $urandom};
          len  = 4'($urandom_range(0, 15));
        end
        default: ;
      endcase
      load_key(text, len);
      steady    = (round % 4 == 3);
      phase_end = chars_sent + $urandom_range(60, 180);
      while (chars_sent < phase_end) begin
        build_line();
        flush_line();
      end
      steady = 1'b0;
      round++;
    end
  endtask

  initial begin
    TIMEOUT_WAIT: #(TIMEOUT_NS);
    $display("testbench: errors");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_character = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    steady       = 1'b0;
    error_count  = 0;
    chars_sent   = 0;
    key_text_q   = '0;
    key_len_q    = '0;
    restart_line();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_number_limits();
    test_empty_values();
    test_first_error();
    test_token_choice();
    test_key_corners();
    test_random_lines();

    settle();
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
